// ===== rtl/swmt_pkg.sv =====
// ----------------------------------------------------------------------------
// swmt_pkg
// Types and constants shared by the sliding window maximum tracker and its
// queue cells.
// ----------------------------------------------------------------------------
`default_nettype none

package swmt_pkg;

  localparam int AMP_W  = 24;
  localparam int TIME_W = 32;
  localparam int CHG_W  = 25;

  typedef logic signed [AMP_W-1:0]  amp_t;
  typedef logic        [TIME_W-1:0] time_t;
  typedef logic signed [CHG_W-1:0]  chg_t;

  // Control broadcast from the top level to every cell of the queue.
  typedef struct packed {
    logic  load;
    logic  shift;
    time_t stime;
    amp_t  samp;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/sliding_window_max_tracker.sv =====
// ----------------------------------------------------------------------------
// sliding_window_max_tracker
// A result is registered in the cycle after its sample transfer. Throughput:
// one sample per cycle unless out_ready stalls; all cells update in parallel.
// Reset clears the queue valid bits and the output valid and loads the
// window span with 4800; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_tracker #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_wr_en,
  input  wire [31:0]               cfg_wr_data,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire [31:0]               in_sample_time,
  input  wire signed [23:0]        in_sample_amp,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [24:0]       out_max_change,
  output logic signed [23:0]       out_window_max,
  output logic                     out_queue_overflow
);

  localparam logic [31:0] SPAN_RESET = 32'd4800;

  logic [31:0]     span_r;
  swmt_pkg::ctrl_t ctrl;
  logic            fire;
  logic            expire;
  logic            zero_front;
  swmt_pkg::time_t age;
  swmt_pkg::amp_t  prev_amp;

  swmt_pkg::amp_t  cell_amp      [QUEUE_DEPTH];
  swmt_pkg::time_t cell_time     [QUEUE_DEPTH];
  swmt_pkg::amp_t  cell_amp_nxt  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_valid;
  logic [QUEUE_DEPTH-1:0] cell_keep;

  logic                   out_valid_r, out_valid_nxt;
  swmt_pkg::chg_t         change_r, change_nxt;
  swmt_pkg::amp_t         wmax_r;
  logic                   ovf_r, ovf_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RESET;
    end else if (cfg_wr_en) begin
      span_r <= cfg_wr_data;
    end
  end

  always_comb begin
    age        = in_sample_time - cell_time[0];
    expire     = cell_valid[0] && (age > span_r);
    zero_front = expire && !cell_valid[1];
    ctrl.load  = fire;
    ctrl.shift = expire && cell_valid[1];
    ctrl.stime = in_sample_time;
    ctrl.samp  = in_sample_amp;
    prev_amp   = cell_valid[0] ? cell_amp[0] : '0;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == QUEUE_DEPTH - 1) begin : g_last
      swmt_cell #(.IS_LAST(1'b1)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_i      (ctrl),
        .clr_amp_i   (1'b0),
        .nb_amp_i    ('0),
        .nb_time_i   ('0),
        .nb_valid_i  (1'b0),
        .prev_keep_i (cell_keep[i-1]),
        .amp_o       (cell_amp[i]),
        .time_o      (cell_time[i]),
        .valid_o     (cell_valid[i]),
        .keep_o      (cell_keep[i]),
        .amp_nxt_o   (cell_amp_nxt[i])
      );
    end else begin : g_mid
      swmt_cell #(.IS_LAST(1'b0)) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl_i      (ctrl),
        .clr_amp_i   ((i == 0) ? zero_front : 1'b0),
        .nb_amp_i    (cell_amp[i+1]),
        .nb_time_i   (cell_time[i+1]),
        .nb_valid_i  (cell_valid[i+1]),
        .prev_keep_i ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i-1]),
        .amp_o       (cell_amp[i]),
        .time_o      (cell_time[i]),
        .valid_o     (cell_valid[i]),
        .keep_o      (cell_keep[i]),
        .amp_nxt_o   (cell_amp_nxt[i])
      );
    end
  end

  always_comb begin
    change_nxt    = swmt_pkg::chg_t'(cell_amp_nxt[0]) - swmt_pkg::chg_t'(prev_amp);
    ovf_nxt       = cell_keep[QUEUE_DEPTH-1];
    out_valid_nxt = fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      change_r <= change_nxt;
      wmax_r   <= cell_amp_nxt[0];
      ovf_r    <= ovf_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_max_change     = change_r;
  assign out_window_max     = wmax_r;
  assign out_queue_overflow = ovf_r;

`ifndef ASSERT_OFF
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("queue valid bits are not a prefix");

  a_front_after_fire: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (cell_valid[0] && out_valid_r))
    else $error("front entry or result missing after sample transfer");

  a_max_is_front: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> (out_window_max == cell_amp[0]))
    else $error("reported maximum differs from front entry");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ovf_nxt) |=> (&cell_valid))
    else $error("overflow reported while queue not full");
`endif

endmodule

`default_nettype wire

// ===== rtl/swmt_cell.sv =====
// ----------------------------------------------------------------------------
// swmt_cell
// One entry of the decreasing queue. It holds an amplitude, a time and a
// valid bit, takes its neighbor's entry when the front expires, drops out
// when the new sample is not smaller, and stores the sample at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module swmt_cell #(
  parameter bit IS_LAST = 1'b0
) (
  input  wire              clk,
  input  wire              rst_n,
  input  swmt_pkg::ctrl_t  ctrl_i,
  input  wire              clr_amp_i,
  input  swmt_pkg::amp_t   nb_amp_i,
  input  swmt_pkg::time_t  nb_time_i,
  input  wire              nb_valid_i,
  input  wire              prev_keep_i,
  output swmt_pkg::amp_t   amp_o,
  output swmt_pkg::time_t  time_o,
  output logic             valid_o,
  output logic             keep_o,
  output swmt_pkg::amp_t   amp_nxt_o
);

  swmt_pkg::amp_t  amp_r, amp_nxt;
  swmt_pkg::time_t time_r, time_nxt;
  logic            valid_r, valid_nxt;
  swmt_pkg::amp_t  e_amp;
  swmt_pkg::time_t e_time;
  logic            e_valid;
  logic            wr;

  always_comb begin
    if (ctrl_i.shift) begin
      e_amp   = nb_amp_i;
      e_time  = nb_time_i;
      e_valid = nb_valid_i;
    end else begin
      e_amp   = clr_amp_i ? '0 : amp_r;
      e_time  = time_r;
      e_valid = valid_r;
    end
    keep_o = e_valid && ($signed(e_amp) > $signed(ctrl_i.samp));
    wr     = prev_keep_i && (IS_LAST || !keep_o);
    if (wr) begin
      amp_nxt  = ctrl_i.samp;
      time_nxt = ctrl_i.stime;
    end else begin
      amp_nxt  = e_amp;
      time_nxt = e_time;
    end
    valid_nxt = keep_o || wr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl_i.load) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      amp_r  <= amp_nxt;
      time_r <= time_nxt;
    end
  end

  assign amp_o     = amp_r;
  assign time_o    = time_r;
  assign valid_o   = valid_r;
  assign amp_nxt_o = amp_nxt;

endmodule

`default_nettype wire
